/* sv/psat_pkg.sv */
package psat_pkg;
  localparam int MAX_VERTS = 16;
  localparam int IDX_W = $clog2(MAX_VERTS);
  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int COORD_W = 20;
  localparam int EDGE_W = 21;
  localparam int PROJ_W = 43;
  localparam logic signed [COORD_W-1:0] CMAX = 20'sh7FFFF;
  localparam logic signed [COORD_W-1:0] CMIN = -20'sh80000;

  // controller -> datapath commands
  typedef struct packed {
    logic             vert_load;   // register transformed vertex for store
    logic             store_wr;    // write pending vertex to store
    logic             clear;       // clear counts, overflow and separated flags
    logic             edge_rd;     // read edge endpoints (poly, index)
    logic             edge_rd2;    // second endpoint read
    logic             edge_calc;   // form normal
    logic             proj_start;  // reset interval trackers
    logic             proj_acc;    // accumulate projection
    logic             eval;        // compare intervals
    logic             edge_poly;   // which polygon owns the edge
    logic [IDX_W-1:0] edge_idx;
    logic [IDX_W-1:0] edge_idx2;
    logic             proj_poly;
    logic [IDX_W-1:0] proj_idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count0;
    logic [CNT_W-1:0] count1;
    logic             overflow;
    logic             separated;
  } status_t;
endpackage

/* sv/polygon_separating_axis_test_unit.sv */
// Separating-axis collision test for two convex polygons. Each transfer loads
// one vertex (rotated about origin by Q1.14 cos/sin, offset by pos, saturated
// to Q16.4) into the store of the polygon named by shape_sel; up to 16 per
// polygon, extra vertices are dropped and flag an error. A vertex without last
// gives no result. A vertex with last then runs the test: for every edge of
// both polygons, fetch the two endpoints and form the normal, then project
// every stored vertex of both polygons, one per cycle, through the single
// store read port, then drain, compare and advance. One result (collides,
// error) follows; touching intervals count as a collision, an empty or
// overflowed polygon gives collides=0, error=1. The next vertex is taken once
// the result transfer completes.
module polygon_separating_axis_test_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               shape_sel,
  input  logic signed [19:0] local_x,
  input  logic signed [19:0] local_y,
  input  logic signed [19:0] origin_x,
  input  logic signed [19:0] origin_y,
  input  logic signed [19:0] pos_x,
  input  logic signed [19:0] pos_y,
  input  logic signed [15:0] cos_a,
  input  logic signed [15:0] sin_a,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               collides,
  output logic               error
);
  psat_pkg::cmd_t    cmd;
  psat_pkg::status_t status;

  psat_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last, .out_valid, .out_ready,
    .collides, .error, .cmd, .status
  );

  psat_datapath u_dp (
    .clk, .rst, .shape_sel, .local_x, .local_y, .origin_x, .origin_y,
    .pos_x, .pos_y, .cos_a, .sin_a, .cmd, .status
  );
endmodule

/* sv/psat_datapath.sv */
module psat_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shape_sel,
  input  logic signed [19:0]                 local_x,
  input  logic signed [19:0]                 local_y,
  input  logic signed [19:0]                 origin_x,
  input  logic signed [19:0]                 origin_y,
  input  logic signed [19:0]                 pos_x,
  input  logic signed [19:0]                 pos_y,
  input  logic signed [15:0]                 cos_a,
  input  logic signed [15:0]                 sin_a,
  input  psat_pkg::cmd_t                     cmd,
  output psat_pkg::status_t                  status
);
  localparam int CW = psat_pkg::COORD_W;
  localparam int EW = psat_pkg::EDGE_W;
  localparam int PW = psat_pkg::PROJ_W;

  logic signed [CW-1:0] mem0_x [psat_pkg::MAX_VERTS];
  logic signed [CW-1:0] mem0_y [psat_pkg::MAX_VERTS];
  logic signed [CW-1:0] mem1_x [psat_pkg::MAX_VERTS];
  logic signed [CW-1:0] mem1_y [psat_pkg::MAX_VERTS];

  logic [psat_pkg::CNT_W-1:0] count0, count1;
  logic overflow;

  // stage 1: four products registered
  logic signed [20:0] px, py;
  logic signed [36:0] m_pc, m_ps, m_qs, m_qc;
  logic signed [CW-1:0] hold_ox, hold_oy, hold_tx, hold_ty;
  logic hold_sel;
  assign px = 21'(local_x) - 21'(origin_x);
  assign py = 21'(local_y) - 21'(origin_y);

  logic signed [37:0] sum_x, sum_y;
  logic signed [23:0] gx_w, gy_w;
  logic signed [CW-1:0] gx, gy;
  assign sum_x = 38'(m_pc) - 38'(m_qs);
  assign sum_y = 38'(m_ps) + 38'(m_qc);
  assign gx_w = 24'(hold_ox) + 24'(sum_x >>> 14) + 24'(hold_tx);
  assign gy_w = 24'(hold_oy) + 24'(sum_y >>> 14) + 24'(hold_ty);
  assign gx = (gx_w > 24'(psat_pkg::CMAX)) ? psat_pkg::CMAX :
              (gx_w < 24'(psat_pkg::CMIN)) ? psat_pkg::CMIN : gx_w[CW-1:0];
  assign gy = (gy_w > 24'(psat_pkg::CMAX)) ? psat_pkg::CMAX :
              (gy_w < 24'(psat_pkg::CMIN)) ? psat_pkg::CMIN : gy_w[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.vert_load) begin
      m_pc <= 37'(px) * 37'(cos_a);
      m_ps <= 37'(px) * 37'(sin_a);
      m_qs <= 37'(py) * 37'(sin_a);
      m_qc <= 37'(py) * 37'(cos_a);
      hold_ox <= origin_x;
      hold_oy <= origin_y;
      hold_tx <= pos_x;
      hold_ty <= pos_y;
      hold_sel <= shape_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count0 <= '0;
      count1 <= '0;
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      count0 <= '0;
      count1 <= '0;
      overflow <= 1'b0;
    end else if (cmd.store_wr) begin
      if (!hold_sel) begin
        if (count0 < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) count0 <= count0 + 1'b1;
        else overflow <= 1'b1;
      end else begin
        if (count1 < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) count1 <= count1 + 1'b1;
        else overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      if (!hold_sel && count0 < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) begin
        mem0_x[count0[psat_pkg::IDX_W-1:0]] <= gx;
        mem0_y[count0[psat_pkg::IDX_W-1:0]] <= gy;
      end
      if (hold_sel && count1 < psat_pkg::CNT_W'(psat_pkg::MAX_VERTS)) begin
        mem1_x[count1[psat_pkg::IDX_W-1:0]] <= gx;
        mem1_y[count1[psat_pkg::IDX_W-1:0]] <= gy;
      end
    end
  end

  // single registered read port shared by both stores; controller sequences addresses
  logic signed [CW-1:0] rd_x, rd_y;
  logic [psat_pkg::IDX_W-1:0] rd_idx;
  logic rd_poly;
  always_comb begin
    rd_poly = cmd.proj_poly;
    rd_idx = cmd.proj_idx;
    if (cmd.edge_rd) begin
      rd_poly = cmd.edge_poly;
      rd_idx = cmd.edge_idx;
    end else if (cmd.edge_rd2) begin
      rd_poly = cmd.edge_poly;
      rd_idx = cmd.edge_idx2;
    end
  end
  always_ff @(posedge clk) begin
    rd_x <= rd_poly ? mem1_x[rd_idx] : mem0_x[rd_idx];
    rd_y <= rd_poly ? mem1_y[rd_idx] : mem0_y[rd_idx];
  end

  logic signed [CW-1:0] a_x, a_y;
  logic signed [EW-1:0] nx, ny;
  always_ff @(posedge clk) begin
    if (cmd.edge_rd2) begin
      a_x <= rd_x;
      a_y <= rd_y;
    end
    if (cmd.edge_calc) begin
      nx <= 21'(a_y) - 21'(rd_y);   // -(ey)
      ny <= 21'(rd_x) - 21'(a_x);   // ex
    end
  end

  // projection: read data -> products -> sum -> trackers
  logic acc_d1, acc_d2, poly_d1, poly_d2;
  logic signed [41:0] mx, my;
  logic signed [PW-1:0] proj;
  logic signed [PW-1:0] lo0, hi0, lo1, hi1;
  assign proj = 43'(mx) + 43'(my);
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_d1 <= 1'b0;
      acc_d2 <= 1'b0;
    end else begin
      acc_d1 <= cmd.proj_acc;
      acc_d2 <= acc_d1;
    end
    poly_d1 <= cmd.proj_poly;
    poly_d2 <= poly_d1;
    mx <= 42'(rd_x) * 42'(nx);
    my <= 42'(rd_y) * 42'(ny);
    if (cmd.proj_start) begin
      lo0 <= {1'b0, {(PW-1){1'b1}}};
      lo1 <= {1'b0, {(PW-1){1'b1}}};
      hi0 <= {1'b1, {(PW-1){1'b0}}};
      hi1 <= {1'b1, {(PW-1){1'b0}}};
    end else if (acc_d2) begin
      if (!poly_d2) begin
        if (proj < lo0) lo0 <= proj;
        if (proj > hi0) hi0 <= proj;
      end else begin
        if (proj < lo1) lo1 <= proj;
        if (proj > hi1) hi1 <= proj;
      end
    end
  end

  logic separated;
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) separated <= 1'b0;
    else if (cmd.eval && (hi0 < lo1 || hi1 < lo0)) separated <= 1'b1;
  end

  assign status.count0 = count0;
  assign status.count1 = count1;
  assign status.overflow = overflow;
  assign status.separated = separated;
endmodule

/* sv/psat_ctrl.sv */
module psat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              collides,
  output logic              error,
  output psat_pkg::cmd_t    cmd,
  input  psat_pkg::status_t status
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STORE = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_EA    = 4'd3;
  localparam logic [3:0] S_EB    = 4'd4;
  localparam logic [3:0] S_EN    = 4'd5;
  localparam logic [3:0] S_PROJ  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_EVAL  = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam int IW = psat_pkg::IDX_W;
  localparam int CW = psat_pkg::CNT_W;

  logic [3:0] state, state_next;
  logic last_q;
  logic edge_poly;
  logic [CW-1:0] edge_i, proj_i;
  logic proj_poly;
  logic [1:0] drain;
  logic [CW-1:0] edge_cnt, proj_cnt, edge_succ;

  assign edge_cnt = edge_poly ? status.count1 : status.count0;
  assign proj_cnt = proj_poly ? status.count1 : status.count0;
  assign edge_succ = (edge_i + 1'b1 < edge_cnt) ? edge_i + 1'b1 : '0;
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.edge_poly = edge_poly;
    cmd.edge_idx = edge_i[IW-1:0];
    cmd.edge_idx2 = edge_succ[IW-1:0];
    cmd.proj_poly = proj_poly;
    cmd.proj_idx = proj_i[IW-1:0];
    cmd.vert_load = in_valid && in_ready;
    cmd.store_wr = (state == S_STORE);
    cmd.edge_rd = (state == S_EA);
    cmd.edge_rd2 = (state == S_EB);
    cmd.edge_calc = (state == S_EN);
    cmd.proj_start = (state == S_EN);
    cmd.proj_acc = (state == S_PROJ);
    cmd.eval = (state == S_EVAL);
    cmd.clear = (state == S_DONE);
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid && in_ready) state_next = S_STORE;
      S_STORE: state_next = last_q ? S_CHECK : S_IDLE;
      S_CHECK: state_next = (status.count0 == '0 || status.count1 == '0 ||
                             status.overflow) ? S_DONE : S_EA;
      S_EA:    state_next = S_EB;
      S_EB:    state_next = S_EN;
      S_EN:    state_next = S_PROJ;
      S_PROJ:  if (proj_poly && proj_i + 1'b1 == proj_cnt) state_next = S_DRAIN;
      S_DRAIN: if (drain == 2'd2) state_next = S_EVAL;
      S_EVAL:  state_next = S_NEXT;
      S_NEXT:  state_next = (edge_poly && edge_i + 1'b1 == edge_cnt) ? S_DONE : S_EA;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      edge_poly <= 1'b0;
      edge_i <= '0;
      proj_poly <= 1'b0;
      proj_i <= '0;
      drain <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (in_valid && in_ready) last_q <= last;
      case (state)
        S_CHECK: begin
          edge_poly <= 1'b0;
          edge_i <= '0;
          collides <= 1'b0;
          error <= 1'b1;
        end
        S_EN: begin
          proj_poly <= 1'b0;
          proj_i <= '0;
          drain <= '0;
        end
        S_PROJ: begin
          if (proj_i + 1'b1 == proj_cnt) begin
            proj_poly <= 1'b1;
            proj_i <= '0;
          end else begin
            proj_i <= proj_i + 1'b1;
          end
        end
        S_DRAIN: drain <= drain + 1'b1;
        S_NEXT: begin
          if (edge_i + 1'b1 == edge_cnt) begin
            edge_poly <= 1'b1;
            edge_i <= '0;
          end else begin
            edge_i <= edge_i + 1'b1;
          end
          error <= 1'b0;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          if (!error) collides <= !status.separated;
        end
        default: ;
      endcase
    end
  end
endmodule

/* sv/psat_checker.sv */
module psat_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic collides,
  input logic error
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken with result pending");
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(collides && error)) else $error("collides with error");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(collides) && $stable(error))
    else $error("result dropped");
  a_no_out_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind polygon_separating_axis_test_unit psat_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .collides, .error
);

/* verif/polygon_separating_axis_test_unit_test.sv */
`timescale 1ns / 100ps

module polygon_separating_axis_test_unit_test;

  typedef struct {
    logic              sel;
    logic signed [19:0] lx, ly, ox, oy, tx, ty;
    logic signed [15:0] c, s;
    logic              last;
  } vertex_t;

  typedef struct {
    logic collides;
    logic error;
  } verdict_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic shape_sel = 0;
  logic signed [19:0] local_x = 0, local_y = 0, origin_x = 0, origin_y = 0;
  logic signed [19:0] pos_x = 0, pos_y = 0;
  logic signed [15:0] cos_a = 0, sin_a = 0;
  logic last = 0;
  logic out_valid;
  logic out_ready = 0;
  logic collides, error;

  polygon_separating_axis_test_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .shape_sel(shape_sel), .local_x(local_x), .local_y(local_y),
    .origin_x(origin_x), .origin_y(origin_y), .pos_x(pos_x), .pos_y(pos_y),
    .cos_a(cos_a), .sin_a(sin_a), .last(last),
    .out_valid(out_valid), .out_ready(out_ready),
    .collides(collides), .error(error)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Predictor copy of the two vertex stores.
  longint store_x[2][psat_pkg::MAX_VERTS];
  longint store_y[2][psat_pkg::MAX_VERTS];
  int     store_cnt[2];
  bit     store_ovf;

  vertex_t  pending_vertices[$];
  verdict_t expected_verdicts[$];
  int n_mismatch = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_hits = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_off = 0;

  function automatic longint floor_div14(longint v);
    return v >>> 14;
  endfunction

  function automatic longint clamp20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // True when some edge normal of polygon a splits a from b.
  function automatic bit edge_splits(int a, int b);
    longint ex, ey, p, lo1, hi1, lo2, hi2;
    int k;
    for (int i = 0; i < store_cnt[a]; i++) begin
      k = (i + 1 < store_cnt[a]) ? i + 1 : 0;
      ex = store_x[a][k] - store_x[a][i];
      ey = store_y[a][k] - store_y[a][i];
      lo1 = 64'sh7FFFFFFFFFFFFFFF; hi1 = -lo1 - 1;
      lo2 = lo1; hi2 = hi1;
      for (int j = 0; j < store_cnt[a]; j++) begin
        p = store_x[a][j] * -ey + store_y[a][j] * ex;
        if (p < lo1) lo1 = p;
        if (p > hi1) hi1 = p;
      end
      for (int j = 0; j < store_cnt[b]; j++) begin
        p = store_x[b][j] * -ey + store_y[b][j] * ex;
        if (p < lo2) lo2 = p;
        if (p > hi2) hi2 = p;
      end
      if (hi1 < lo2 || hi2 < lo1) return 1;
    end
    return 0;
  endfunction

  // Load one vertex into the predictor; queue a verdict when it closes a batch.
  function automatic void predict_collision(vertex_t v);
    longint px, py, gx, gy;
    int sel;
    verdict_t r;
    sel = v.sel;
    px = longint'(v.lx) - longint'(v.ox);
    py = longint'(v.ly) - longint'(v.oy);
    gx = clamp20(v.ox + floor_div14(px * v.c - py * v.s) + v.tx);
    gy = clamp20(v.oy + floor_div14(px * v.s + py * v.c) + v.ty);
    if (store_cnt[sel] < psat_pkg::MAX_VERTS) begin
      store_x[sel][store_cnt[sel]] = gx;
      store_y[sel][store_cnt[sel]] = gy;
      store_cnt[sel]++;
    end else
      store_ovf = 1;
    if (!v.last) return;
    if (store_cnt[0] == 0 || store_cnt[1] == 0 || store_ovf) begin
      r.collides = 0; r.error = 1;
    end else begin
      r.collides = !(edge_splits(0, 1) || edge_splits(1, 0));
      r.error = 0;
    end
    expected_verdicts.push_back(r);
    store_cnt[0] = 0; store_cnt[1] = 0; store_ovf = 0;
  endfunction

  function automatic logic signed [19:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return -20'sd524288;
      1: return 20'sd524287;
      2: return 20'($urandom);
      default: return $signed(20'($urandom_range(0, 4000))) - 20'sd2000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_trig();
    case ($urandom_range(0, 6))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  // Queue one batch: a polygon of n0 vertices, one of n1, last on the final vertex.
  task automatic queue_batch(int n0, int n1, bit wild);
    vertex_t v;
    logic signed [19:0] cx[2], cy[2], ox[2], oy[2], tx[2], ty[2];
    logic signed [15:0] c[2], s[2];
    int total, idx, sel, ang, r;
    for (int p = 0; p < 2; p++) begin
      cx[p] = $signed(20'($urandom_range(0, 3000))) - 20'sd1500;
      cy[p] = $signed(20'($urandom_range(0, 3000))) - 20'sd1500;
      ox[p] = wild ? rand_coord() : cx[p];
      oy[p] = wild ? rand_coord() : cy[p];
      tx[p] = wild ? rand_coord() : $signed(20'($urandom_range(0, 400))) - 20'sd200;
      ty[p] = wild ? rand_coord() : $signed(20'($urandom_range(0, 400))) - 20'sd200;
      ang = $urandom_range(0, 7);
      c[p] = wild ? rand_trig() : ((ang % 2) ? 16'sd11585 : 16'sd16384);
      s[p] = wild ? rand_trig() : ((ang % 2) ? 16'sd11585 : 16'sd0);
    end
    total = n0 + n1;
    for (int i = 0; i < total; i++) begin
      sel = (i < n0) ? 0 : 1;
      idx = (sel == 0) ? i : i - n0;
      r = $urandom_range(50, 900);
      if (wild) begin
        v.lx = rand_coord(); v.ly = rand_coord();
      end else begin
        // Walk a convex regular-ish shape counterclockwise.
        v.lx = cx[sel] + 20'($rtoi(r * $cos(6.2832 * idx / ((sel ? n1 : n0) + 0.0))));
        v.ly = cy[sel] + 20'($rtoi(r * $sin(6.2832 * idx / ((sel ? n1 : n0) + 0.0))));
      end
      v.sel = 1'(sel);
      v.ox = ox[sel]; v.oy = oy[sel]; v.tx = tx[sel]; v.ty = ty[sel];
      v.c = c[sel]; v.s = s[sel];
      v.last = (i == total - 1);
      pending_vertices.push_back(v);
      n_sent++;
    end
  endtask

  // Driver: hold the payload until the transfer completes.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_collision(pending_vertices.pop_front());
      if (pending_vertices.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin : load
        vertex_t v;
        v = pending_vertices[0];
        in_valid <= 1;
        shape_sel <= v.sel; local_x <= v.lx; local_y <= v.ly;
        origin_x <= v.ox; origin_y <= v.oy; pos_x <= v.tx; pos_y <= v.ty;
        cos_a <= v.c; sin_a <= v.s; last <= v.last;
      end else
        in_valid <= 0;
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering.
  initial begin : hold_window
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1;
    repeat (3000) @(posedge clk);
    hold_off <= 0;
  end

  // Monitor: compare each verdict transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_verdicts.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected verdict collides=%0d error=%0d",
                                         collides, error);
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (e.error) n_errors++;
          if (e.collides) n_hits++;
          if (e.collides !== collides || e.error !== error) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("verdict %0d: expected collides=%0d error=%0d, got %0d %0d",
                       n_results, e.collides, e.error, collides, error);
          end
        end
      end
      if (hold_off)
        out_ready <= 0;
      else
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_vertices.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    store_cnt[0] = 0; store_cnt[1] = 0; store_ovf = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // Directed: minimal shapes, empty polygons, touching squares, overfull store.
    queue_batch(1, 1, 0);
    queue_batch(3, 4, 0);
    queue_batch(0, 2, 0);
    queue_batch(2, 0, 0);
    begin : touching
      vertex_t v;
      int sq[4][2] = '{'{0, 0}, '{160, 0}, '{160, 160}, '{0, 160}};
      for (int p = 0; p < 2; p++)
        for (int i = 0; i < 4; i++) begin
          v.sel = 1'(p); v.lx = 20'(sq[i][0] + p * 160); v.ly = 20'(sq[i][1]);
          v.ox = '0; v.oy = '0; v.tx = '0; v.ty = '0; v.c = 16'sd16384; v.s = '0;
          v.last = (p == 1 && i == 3);
          pending_vertices.push_back(v);
        end
    end
    queue_batch(17, 2, 0);
    queue_batch(2, 2, 1);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 79) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 79) : 0;
      if (ph == 0) hold_req = 1;
      while (n_sent < (ph + 1) * 450) begin
        case ($urandom_range(0, 9))
          0: queue_batch($urandom_range(0, 2), $urandom_range(1, 3), 1);
          1: queue_batch($urandom_range(15, 17), $urandom_range(1, 16), 0);
          default: queue_batch($urandom_range(1, 6), $urandom_range(1, 6),
                               $urandom_range(0, 3) == 0);
        endcase
        wait (pending_vertices.size() < 40);
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);
    $display("Ran %0d vertices giving %0d verdicts: %0d collisions, %0d errors",
             n_sent, n_results, n_hits, n_errors);
    if (n_mismatch == 0 && expected_verdicts.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end
endmodule

/* polygon_separating_axis_test_unit.f */
sv/psat_pkg.sv
sv/psat_datapath.sv
sv/psat_ctrl.sv
sv/polygon_separating_axis_test_unit.sv
sv/psat_checker.sv
verif/polygon_separating_axis_test_unit_test.sv
